/* src/pidz_pkg.sv */
package pidz_pkg;

  // Field and register widths
  localparam int GAIN_W     = 16;
  localparam int LP_W       = 8;
  localparam int ZONE_W     = 23;
  localparam int OUT_W      = 16;
  localparam int CLAMP_W    = 8;
  localparam int CLAMP_LIM  = 127;
  localparam int QUO_W      = 16;
  localparam int MCNT_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [LP_W-1:0] LP_RESET = 8'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd5;

  // Command to the shift-add multiplier
  typedef struct packed {
    logic              start;
    logic [MCNT_W-1:0] nbits;
  } mac_cmd_t;

endpackage

/* src/pid_controller_active_zone_top.sv */
// PID controller with an integral active zone and an integral clamp.
// Input channel (in_valid/in_stall): one control tick carrying in_run_enable,
// in_setpoint and in_measured; a tick is taken when in_valid is high and
// in_stall is low. Result channel (out_valid/out_stall): one drive value and
// its +-127 clamped copy for every tick, in order.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes the
// gains, active zone, integral limit and loop period; cfg_ready is always high.
// Work: an enabled tick passes through one shared shift-add multiplier (three
// 16-step and two 9-step passes) and a 16-step restoring divider for the
// rounded scale by the loop period; a disabled tick repeats the held output.
// in_stall is high while a tick is in work, so a new tick is taken only after
// the last one has been passed to the output register.
// Reset (rst_n low at a clock edge) clears gains, zone and limit, sets the loop
// period to 10 and zeroes the integral, prior error and held output.
// A stalled result holds in the output register; the finished next result
// waits until that register is free, and the input stays stalled meanwhile.
module pid_controller_active_zone_top #(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_run_enable,
  input  logic signed [SAMPLE_BITS-1:0]       in_setpoint,
  input  logic signed [SAMPLE_BITS-1:0]       in_measured,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pidz_pkg::OUT_W-1:0]   out_drive_value,
  output logic signed [pidz_pkg::CLAMP_W-1:0] out_drive_clamped,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pidz_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidz_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pidz_pkg::*;

  localparam int ERR_W  = SAMPLE_BITS + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int ACC_W  = ZONE_W + GAIN_FRAC_BITS + 1;
  localparam int P_W    = GAIN_W + ERR_W;
  // Headroom: sum carry, scale by the loop period, derivative add
  localparam int NUM_W  = ((P_W > ACC_W) ? P_W : ACC_W) + LP_W + 3;
  localparam int CMP_W  = (ERR_W > ZONE_W) ? ERR_W : ZONE_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_KI,
    ST_KILP,
    ST_CLAMP,
    ST_KP,
    ST_LP,
    ST_KD,
    ST_ROUND,
    ST_DIV,
    ST_DIVW,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   drive_value_r, drive_value_nxt;
  logic [CLAMP_W-1:0] drive_clamped_r, drive_clamped_nxt;
  logic               hold_r, hold_nxt;
  logic [ACC_W-1:0]   integ_r, integ_nxt;
  logic [ERR_W-1:0]   prior_r, prior_nxt;
  logic [OUT_W-1:0]   held_r, held_nxt;

  logic [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic [ZONE_W-1:0]  zone_r, limit_r;
  logic [LP_W-1:0]    loop_r;

  logic [ERR_W-1:0]   err_r, err_nxt;
  logic               in_zone_r, in_zone_nxt;
  logic [NUM_W-1:0]   work_r, work_nxt;
  logic               neg_r, neg_nxt;
  logic [OUT_W-1:0]   res_r, res_nxt;

  logic [LP_W-1:0]    lp_eff;
  logic [ERR_W-1:0]   err_calc, err_mag;
  logic [DIFF_W-1:0]  diff;
  logic [NUM_W-1:0]   err_ext, diff_ext, integ_ext, lim_ext, lim_neg, half;
  logic [OUT_W-1:0]   q_final, res_out;
  logic [CLAMP_W-1:0] clamp_out;

  mac_cmd_t           mac_cmd;
  logic [NUM_W-1:0]   mac_mcand, mac_init, mac_res;
  logic [GAIN_W-1:0]  mac_mplier;
  logic               mac_done;
  logic               div_start, div_done;
  logic [QUO_W-1:0]   div_q;

  pidz_mac #(.NUM_W(NUM_W)) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (mac_cmd),
    .mcand    (mac_mcand),
    .mplier   (mac_mplier),
    .acc_init (mac_init),
    .done     (mac_done),
    .result   (mac_res)
  );

  pidz_div #(.NUM_W(NUM_W), .FRAC_W(GAIN_FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (work_r),
    .divisor  (lp_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // Operand formatting
  assign lp_eff    = (loop_r == '0) ? LP_W'(1) : loop_r;
  assign err_calc  = {in_setpoint[SAMPLE_BITS-1], in_setpoint}
                   - {in_measured[SAMPLE_BITS-1], in_measured};
  assign err_mag   = err_r[ERR_W-1] ? (~err_r + 1'b1) : err_r;
  assign diff      = {err_r[ERR_W-1], err_r} - {prior_r[ERR_W-1], prior_r};
  assign err_ext   = {{(NUM_W-ERR_W){err_r[ERR_W-1]}}, err_r};
  assign diff_ext  = {{(NUM_W-DIFF_W){diff[DIFF_W-1]}}, diff};
  assign integ_ext = {{(NUM_W-ACC_W){integ_r[ACC_W-1]}}, integ_r};
  assign lim_ext   = NUM_W'(limit_r) << GAIN_FRAC_BITS;
  assign lim_neg   = ~lim_ext + 1'b1;
  assign half      = (NUM_W'(lp_eff) << GAIN_FRAC_BITS) >> 1;

  // Apply sign and saturate to 16 bits
  assign q_final = neg_r ? (~div_q + 1'b1)
                 : (div_q[QUO_W-1] ? {1'b0, {(OUT_W-1){1'b1}}} : div_q);

  // Result of this tick and its clamped copy
  assign res_out = hold_r ? held_r : res_r;
  always_comb begin
    if ($signed(res_out) > CLAMP_LIM) begin
      clamp_out = CLAMP_W'(CLAMP_LIM);
    end else if ($signed(res_out) < -CLAMP_LIM) begin
      clamp_out = CLAMP_W'(-CLAMP_LIM);
    end else begin
      clamp_out = res_out[CLAMP_W-1:0];
    end
  end

  // Sequence the tick through the multiplier and divider
  always_comb begin
    state_nxt         = state_r;
    out_valid_nxt     = out_valid_r && out_stall;
    drive_value_nxt   = drive_value_r;
    drive_clamped_nxt = drive_clamped_r;
    hold_nxt          = hold_r;
    integ_nxt         = integ_r;
    prior_nxt         = prior_r;
    held_nxt          = held_r;
    err_nxt           = err_r;
    in_zone_nxt       = in_zone_r;
    work_nxt          = work_r;
    neg_nxt           = neg_r;
    res_nxt           = res_r;
    mac_cmd           = '0;
    mac_mcand         = '0;
    mac_mplier        = '0;
    mac_init          = '0;
    div_start         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          err_nxt   = err_calc;
          hold_nxt  = !in_run_enable;
          state_nxt = in_run_enable ? ST_ERR : ST_DONE;
        end
      end
      ST_ERR: begin
        in_zone_nxt   = (CMP_W'(err_mag) <= CMP_W'(zone_r));
        mac_cmd.start = 1'b1;
        mac_cmd.nbits = MCNT_W'(GAIN_W);
        mac_mcand     = err_ext;
        mac_mplier    = gain_i_r;
        state_nxt     = ST_KI;
      end
      ST_KI: begin
        if (mac_done) begin
          mac_cmd.start = 1'b1;
          mac_cmd.nbits = MCNT_W'(LP_W + 1);
          mac_mcand     = mac_res;
          mac_mplier    = GAIN_W'(lp_eff);
          state_nxt     = ST_KILP;
        end
      end
      ST_KILP: begin
        if (mac_done) begin
          work_nxt  = integ_ext + mac_res;
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        // Clamp inside the zone, drop the integral outside it
        if (!in_zone_r) begin
          integ_nxt = '0;
        end else if ($signed(work_r) > $signed(lim_ext)) begin
          integ_nxt = ACC_W'(lim_ext);
        end else if ($signed(work_r) < $signed(lim_neg)) begin
          integ_nxt = ACC_W'(lim_neg);
        end else begin
          integ_nxt = ACC_W'(work_r);
        end
        mac_cmd.start = 1'b1;
        mac_cmd.nbits = MCNT_W'(GAIN_W);
        mac_mcand     = err_ext;
        mac_mplier    = gain_p_r;
        state_nxt     = ST_KP;
      end
      ST_KP: begin
        if (mac_done) begin
          mac_cmd.start = 1'b1;
          mac_cmd.nbits = MCNT_W'(LP_W + 1);
          mac_mcand     = mac_res + integ_ext;
          mac_mplier    = GAIN_W'(lp_eff);
          state_nxt     = ST_LP;
        end
      end
      ST_LP: begin
        if (mac_done) begin
          mac_cmd.start = 1'b1;
          mac_cmd.nbits = MCNT_W'(GAIN_W);
          mac_mcand     = diff_ext;
          mac_mplier    = gain_d_r;
          mac_init      = mac_res;
          state_nxt     = ST_KD;
        end
      end
      ST_KD: begin
        if (mac_done) begin
          work_nxt  = mac_res;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // Magnitude plus half the divisor for round half away from zero
        neg_nxt   = work_r[NUM_W-1];
        work_nxt  = work_r[NUM_W-1] ? (half - work_r) : (work_r + half);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          res_nxt   = q_final;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          drive_value_nxt   = res_out;
          drive_clamped_nxt = clamp_out;
          held_nxt          = res_out;
          if (!hold_r) begin
            prior_nxt = err_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, controller state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      drive_value_r   <= '0;
      drive_clamped_r <= '0;
      hold_r          <= 1'b0;
      integ_r         <= '0;
      prior_r         <= '0;
      held_r          <= '0;
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      drive_value_r   <= drive_value_nxt;
      drive_clamped_r <= drive_clamped_nxt;
      hold_r          <= hold_nxt;
      integ_r         <= integ_nxt;
      prior_r         <= prior_nxt;
      held_r          <= held_nxt;
    end
  end

  // Advance working registers
  always_ff @(posedge clk) begin
    err_r     <= err_nxt;
    in_zone_r <= in_zone_nxt;
    work_r    <= work_nxt;
    neg_r     <= neg_nxt;
    res_r     <= res_nxt;
  end

  // Take configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      zone_r   <= '0;
      limit_r  <= '0;
      loop_r   <= LP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P: gain_p_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I: gain_i_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D: gain_d_r <= cfg_data[GAIN_W-1:0];
        REG_ZONE:   zone_r   <= cfg_data[ZONE_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_data[ZONE_W-1:0];
        REG_PERIOD: loop_r   <= cfg_data[LP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready         = 1'b1;
  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_drive_value   = drive_value_r;
  assign out_drive_clamped = drive_clamped_r;

`ifndef NO_ASSERTIONS
  a_accept_starts_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_ERR || state_r == ST_DONE))
    else $error("accepted tick did not start work");

  a_clamp_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> drive_clamped_r[CLAMP_W-1] == drive_value_r[OUT_W-1])
    else $error("clamped copy disagrees in sign with drive value");
`endif

endmodule

/* src/pidz_mac.sv */
module pidz_mac #(
  parameter int NUM_W = 52
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pidz_pkg::mac_cmd_t            cmd,
  input  logic [NUM_W-1:0]              mcand,
  input  logic [pidz_pkg::GAIN_W-1:0]   mplier,
  input  logic [NUM_W-1:0]              acc_init,
  output logic                          done,
  output logic [NUM_W-1:0]              result
);
  import pidz_pkg::*;

  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic [NUM_W-1:0]  mcand_r, mcand_nxt;
  logic [GAIN_W-1:0] mplier_r, mplier_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;

  // Retire one multiplier bit per cycle, LSB first; the top bit carries negative weight
  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    if (cmd.start) begin
      acc_nxt    = acc_init;
      mcand_nxt  = mcand;
      mplier_nxt = mplier;
      cnt_nxt    = cmd.nbits;
    end else if (cnt_r != '0) begin
      if (mplier_r[0]) begin
        if (cnt_r == MCNT_W'(1)) begin
          acc_nxt = acc_r - mcand_r;
        end else begin
          acc_nxt = acc_r + mcand_r;
        end
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - MCNT_W'(1);
      done_nxt   = (cnt_r == MCNT_W'(1));
    end
  end

  // Hold step count and completion flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

`ifndef NO_ASSERTIONS
  a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(cnt_r == MCNT_W'(1)))
    else $error("multiplier done without a final step");

  a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> cnt_r == '0)
    else $error("multiplier restarted while busy");
`endif

endmodule

/* src/pidz_div.sv */
module pidz_div #(
  parameter int NUM_W  = 52,
  parameter int FRAC_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [NUM_W-1:0]            dividend,
  input  logic [pidz_pkg::LP_W-1:0]   divisor,
  output logic                        done,
  output logic [pidz_pkg::QUO_W-1:0]  quotient
);
  import pidz_pkg::*;

  localparam int HIGH_W = NUM_W - FRAC_W - QUO_W;

  logic [HIGH_W-1:0] high;
  logic [LP_W:0]     trial;
  logic [LP_W:0]     trial_sub;
  logic [LP_W-1:0]   rem_r, rem_nxt;
  logic [QUO_W-1:0]  dig_r, dig_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic              sat_r, sat_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;

  assign high      = dividend[NUM_W-1 -: HIGH_W];
  assign trial     = {rem_r, dig_r[QUO_W-1]};
  assign trial_sub = trial - {1'b0, divisor};

  // Restoring division, one quotient bit per cycle; remainder stays below divisor
  always_comb begin
    rem_nxt  = rem_r;
    dig_nxt  = dig_r;
    quo_nxt  = quo_r;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      sat_nxt = (high >= {{(HIGH_W-LP_W){1'b0}}, divisor});
      rem_nxt = high[LP_W-1:0];
      dig_nxt = dividend[FRAC_W +: QUO_W];
      quo_nxt = '0;
      cnt_nxt = MCNT_W'(QUO_W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial_sub[LP_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[LP_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      dig_nxt  = dig_r << 1;
      cnt_nxt  = cnt_r - MCNT_W'(1);
      done_nxt = (cnt_r == MCNT_W'(1));
    end
  end

  // Hold step count and completion flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dig_r <= dig_nxt;
    quo_r <= quo_nxt;
    sat_r <= sat_nxt;
  end

  // Saturate the magnitude at 32768
  assign quotient = (sat_r || quo_r[QUO_W-1]) ? {1'b1, {(QUO_W-1){1'b0}}} : quo_r;
  assign done     = done_r;

`ifndef NO_ASSERTIONS
  a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> cnt_r == '0)
    else $error("divider restarted while busy");
`endif

endmodule
